// File: rtl/annexb_pkg.sv
// ----------------------------------------------------------------------------
// annexb_pkg
// Shared widths, constants and the burst plan type of the Annex-B splitter.
// ----------------------------------------------------------------------------
package annexb_pkg;

    localparam int BYTE_W = 8;
    localparam int ZRUN_W = 6;
    localparam int USER_W = 2;

    // cap of the pending zero count
    localparam logic [ZRUN_W-1:0] ZERO_RUN_MAX = 6'd62;
    // zeros that must precede a 01 byte to form a start code
    localparam logic [ZRUN_W-1:0] START_CODE_ZEROS = 6'd2;

    // words released by one input byte, in order: pre, zeros, post
    typedef struct packed {
        logic              pre_v;
        logic [BYTE_W-1:0] pre_b;
        logic              pre_last;
        logic [ZRUN_W-1:0] zcnt;
        logic              post_v;
        logic [BYTE_W-1:0] post_b;
        logic              first;
    } t_plan;

endpackage

// File: rtl/annexb_parse.sv
// ----------------------------------------------------------------------------
// annexb_parse
// Input skid stage and start code parser; turns each byte into a burst plan.
// ----------------------------------------------------------------------------
module annexb_parse
    import annexb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_s_tlast,
    output t_plan             o_plan,
    output logic              o_plan_v,
    input  logic              i_burst_rdy
);

    logic              r_in_v, n_in_v;
    logic [BYTE_W-1:0] r_in_b, n_in_b;
    logic              r_in_last, n_in_last;
    logic              r_skid_v, n_skid_v;
    logic [BYTE_W-1:0] r_skid_b, n_skid_b;
    logic              r_skid_last, n_skid_last;

    logic              r_inside, n_inside;
    logic [ZRUN_W-1:0] r_zrun, n_zrun;
    logic [BYTE_W-1:0] r_held_b, n_held_b;
    logic              r_held_v, n_held_v;
    logic              r_firstp, n_firstp;

    logic  acc, take, is_zero, is_sc;
    t_plan plan;

    assign o_s_tready = !r_skid_v;
    assign acc        = i_s_tvalid && !r_skid_v;
    assign take       = r_in_v && i_burst_rdy;

    // skid stage
    always_comb begin
        n_in_v      = r_in_v;
        n_in_b      = r_in_b;
        n_in_last   = r_in_last;
        n_skid_v    = r_skid_v;
        n_skid_b    = r_skid_b;
        n_skid_last = r_skid_last;
        if (take) begin
            if (r_skid_v) begin
                n_in_b    = r_skid_b;
                n_in_last = r_skid_last;
                n_skid_v  = 1'b0;
            end else if (acc) begin
                n_in_b    = i_s_tdata;
                n_in_last = i_s_tlast;
            end else begin
                n_in_v = 1'b0;
            end
        end else if (acc) begin
            if (!r_in_v) begin
                n_in_v    = 1'b1;
                n_in_b    = i_s_tdata;
                n_in_last = i_s_tlast;
            end else begin
                n_skid_v    = 1'b1;
                n_skid_b    = i_s_tdata;
                n_skid_last = i_s_tlast;
            end
        end
    end

    // parser
    assign is_zero = (r_in_b == '0);
    assign is_sc   = (r_in_b == 8'h01) && (r_zrun >= START_CODE_ZEROS);

    always_comb begin
        plan     = '0;
        n_inside = r_inside;
        n_zrun   = r_zrun;
        n_held_b = r_held_b;
        n_held_v = r_held_v;
        n_firstp = r_firstp;
        if (is_zero) begin
            if (r_zrun < ZERO_RUN_MAX) begin
                n_zrun = r_zrun + 1'b1;
            end else if (r_inside) begin
                plan.pre_v = r_held_v;
                plan.pre_b = r_held_b;
                n_held_b   = '0;
                n_held_v   = 1'b1;
            end
        end else if (is_sc) begin
            plan.pre_v    = r_inside && r_held_v;
            plan.pre_b    = r_held_b;
            plan.pre_last = 1'b1;
            n_inside      = 1'b1;
            n_held_v      = 1'b0;
            n_zrun        = '0;
        end else begin
            if (r_inside) begin
                plan.pre_v = r_held_v;
                plan.pre_b = r_held_b;
                plan.zcnt  = r_zrun;
                n_held_b   = r_in_b;
                n_held_v   = 1'b1;
            end
            n_zrun = '0;
        end
        plan.first = r_firstp;
        if (is_sc) begin
            n_firstp = 1'b1;
        end else if (plan.pre_v || (plan.zcnt != '0)) begin
            n_firstp = 1'b0;
        end
        // end of message: flush the held byte and start over
        if (r_in_last) begin
            plan.post_v = n_inside && n_held_v;
            plan.post_b = n_held_b;
            n_inside    = 1'b0;
            n_zrun      = '0;
            n_held_v    = 1'b0;
            n_firstp    = 1'b1;
        end
    end

    assign o_plan   = plan;
    assign o_plan_v = take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_skid_v <= 1'b0;
            r_inside <= 1'b0;
            r_zrun   <= '0;
            r_held_v <= 1'b0;
            r_firstp <= 1'b1;
        end else begin
            r_in_v   <= n_in_v;
            r_skid_v <= n_skid_v;
            if (take) begin
                r_inside <= n_inside;
                r_zrun   <= n_zrun;
                r_held_v <= n_held_v;
                r_firstp <= n_firstp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_b      <= n_in_b;
        r_in_last   <= n_in_last;
        r_skid_b    <= n_skid_b;
        r_skid_last <= n_skid_last;
        if (take) begin
            r_held_b <= n_held_b;
        end
    end

`ifndef SYNTHESIS
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_in_v)
        else $error("skid word present with empty main stage");

    a_zrun_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zrun <= ZERO_RUN_MAX)
        else $error("pending zero count above cap");

    a_held_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_v |-> r_inside)
        else $error("held byte outside a unit");
`endif

endmodule

// File: rtl/annexb_burst.sv
// ----------------------------------------------------------------------------
// annexb_burst
// Burst engine: plays out one plan into the output register, a word per cycle unless stalled.
// ----------------------------------------------------------------------------
module annexb_burst
    import annexb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_plan             i_plan,
    input  logic              i_plan_v,
    output logic              o_burst_rdy,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    output logic [USER_W-1:0] o_m_tuser
);

    t_plan             r_plan, n_plan;
    logic              r_out_v;
    logic [BYTE_W-1:0] r_out_b;
    logic              r_out_first, r_out_last, r_out_blast;

    logic              busy, out_rdy, adv;
    logic [BYTE_W-1:0] e_b;
    logic              e_last, e_blast;

    assign busy    = r_plan.pre_v || (r_plan.zcnt != '0) || r_plan.post_v;
    assign out_rdy = !r_out_v || i_m_tready;
    assign adv     = busy && out_rdy;

    // pick the next word of the burst
    always_comb begin
        e_b     = '0;
        e_last  = 1'b0;
        e_blast = 1'b0;
        if (r_plan.pre_v) begin
            e_b     = r_plan.pre_b;
            e_last  = r_plan.pre_last;
            e_blast = (r_plan.zcnt == '0) && !r_plan.post_v;
        end else if (r_plan.zcnt != '0) begin
            e_blast = (r_plan.zcnt == 6'd1) && !r_plan.post_v;
        end else begin
            e_b     = r_plan.post_b;
            e_last  = 1'b1;
            e_blast = 1'b1;
        end
    end

    assign o_burst_rdy = !busy || (out_rdy && e_blast);

    always_comb begin
        n_plan = r_plan;
        if (i_plan_v) begin
            n_plan = i_plan;
        end else if (adv) begin
            n_plan.first = 1'b0;
            if (r_plan.pre_v) begin
                n_plan.pre_v = 1'b0;
            end else if (r_plan.zcnt != '0) begin
                n_plan.zcnt = r_plan.zcnt - 1'b1;
            end else begin
                n_plan.post_v = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plan  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_plan <= n_plan;
            if (adv) begin
                r_out_v <= 1'b1;
            end else if (i_m_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_b     <= e_b;
            r_out_first <= r_plan.first;
            r_out_last  <= e_last;
            r_out_blast <= e_blast;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_b;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_blast, r_out_first};

`ifndef SYNTHESIS
    a_burst_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_blast) |-> busy)
        else $error("burst ended without a burst_last word");

    a_zcnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_plan_v |-> (i_plan.zcnt <= ZERO_RUN_MAX))
        else $error("plan with more zeros than the cap");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_m_tready) |=>
            (r_out_v && $stable(r_out_b) && $stable(r_out_last) && $stable(r_out_blast)))
        else $error("output word changed while stalled");
`endif

endmodule

// File: rtl/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an H.264 Annex-B byte stream into NAL unit payload bytes.
// ----------------------------------------------------------------------------
// Takes one stream byte per word with tlast on the last byte of a message and
// emits the payload bytes of each NAL unit with the 00 00 01 start code
// removed (a 4-byte code is covered: its extra zero is stripped as a trailing
// zero of the unit before it). Up to 62 trailing zeros of a unit are
// stripped, empty units give nothing, bytes before the first start code of
// a message are dropped, and every message is parsed on its own. The newest
// byte is held back until the next byte shows whether it ends its unit, so
// output lags the input. Throughput: one input byte per cycle while the
// output is ready and each byte releases at most one output word; a byte
// that releases n words (a held byte, a run of up to 62 pending zeros and a
// final flush on message end, at most 64 words) holds the burst engine
// until its last word is out, during which the two-entry input skid fills
// and then stalls the input. No clearing pass is needed after reset. An
// accepted byte's first word passes the input, plan and output registers.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
    import annexb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input stream
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BYTE_W-1:0] i_s_axis_tdata,   // [7:0] stream_byte
    input  logic              i_s_axis_tlast,   // message_end
    // output stream
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [BYTE_W-1:0] o_m_axis_tdata,   // [7:0] nal_byte
    output logic              o_m_axis_tlast,   // nal_last
    output logic [USER_W-1:0] o_m_axis_tuser    // [0] nal_first, [1] burst_last
);

    // plan of words released by the byte just parsed
    t_plan plan;
    logic  plan_v;
    logic  burst_rdy;

    // parser: skid stage, start code detection, held byte and zero count
    annexb_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .o_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tlast   (i_s_axis_tlast),
        .o_plan      (plan),
        .o_plan_v    (plan_v),
        .i_burst_rdy (burst_rdy)
    );

    // burst engine: advance one word per cycle into the output register while the output is ready
    annexb_burst u_burst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_plan      (plan),
        .i_plan_v    (plan_v),
        .o_burst_rdy (burst_rdy),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast),
        .o_m_tuser   (o_m_axis_tuser)
    );

endmodule

// File: test/annexb_nal_unit_splitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_test
// Self-checking bench for the Annex-B NAL unit splitter.
// ----------------------------------------------------------------------------
// A short directed message set walks the start code forms, empty units, zero
// stripping and message ends; then random messages follow, mostly well-formed
// start code / payload sequences with random content and some raw noise.
// Every accepted input word runs through a local model of the splitter, which
// queues the words it should release; the monitor checks each output word
// against the oldest queued one. Both sides idle at random and the receiver
// holds off once for a long stretch so the input side backs up.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_test;
    import annexb_pkg::*;

    localparam int RANDOM_BYTES = 480;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int HOLD_AFTER   = 80;    // output words seen before the hold-off
    localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake on either side
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              msg_end;
    } t_stream_word;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              burst_end;
    } t_nal_word;

    typedef enum logic [1:0] {
        RX_FREE,      // always ready
        RX_COIN,      // ready half the time
        RX_PERIODIC,  // ready unless the phase counter reads 3
        RX_SPARSE     // ready at random, with a chance of one in four
    } t_rx_mode;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;
    logic [USER_W-1:0] m_tuser;

    t_stream_word pending_bytes[$];
    t_nal_word    expected_words[$];

    // splitter model state
    logic              inside_unit = 1'b0;
    logic [ZRUN_W-1:0] zero_run = '0;
    logic [BYTE_W-1:0] held_byte = '0;
    logic              held_valid = 1'b0;
    logic              first_pending = 1'b1;

    int err_count = 0;
    int in_words = 0;
    int out_words = 0;
    int messages = 0;
    int units = 0;
    int longest_burst = 0;
    int cap_releases = 0;

    annexb_nal_unit_splitter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // [7:0] stream_byte
        .i_s_axis_tlast  (s_tlast),    // message_end
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // [7:0] nal_byte
        .o_m_axis_tlast  (m_tlast),    // nal_last
        .o_m_axis_tuser  (m_tuser)     // [0] nal_first, [1] burst_last
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Splitter model
    // ------------------------------------------------------------------------
    task automatic emit_nal_word(input logic [BYTE_W-1:0] b, input logic last);
        t_nal_word w;
        w.data      = b;
        w.first     = first_pending;
        w.last      = last;
        w.burst_end = 1'b0;
        expected_words.insert(expected_words.size(), w);
        first_pending = 1'b0;
    endtask

    // Work out the words one accepted stream byte releases and queue them.
    task automatic split_stream_byte(input logic [BYTE_W-1:0] b, input logic msg_end);
        int        base;
        int        burst;
        t_nal_word w;
        base = expected_words.size();
        if (b == 8'h00) begin
            if (zero_run < ZERO_RUN_MAX) begin
                zero_run = zero_run + 1'b1;
            end else if (inside_unit) begin
                // count stays at the cap: release the held byte and hold one zero
                if (held_valid) begin
                    emit_nal_word(held_byte, 1'b0);
                end
                held_byte  = 8'h00;
                held_valid = 1'b1;
                cap_releases++;
            end
        end else if (b == 8'h01 && zero_run >= START_CODE_ZEROS) begin
            // start code: close the unit in progress, drop its trailing zeros
            if (inside_unit && held_valid) begin
                emit_nal_word(held_byte, 1'b1);
            end
            inside_unit   = 1'b1;
            first_pending = 1'b1;
            held_valid    = 1'b0;
            zero_run      = '0;
        end else begin
            if (inside_unit) begin
                if (held_valid) begin
                    emit_nal_word(held_byte, 1'b0);
                end
                while (zero_run != 0) begin
                    emit_nal_word(8'h00, 1'b0);
                    zero_run = zero_run - 1'b1;
                end
                held_byte  = b;
                held_valid = 1'b1;
            end
            zero_run = '0;
        end
        if (msg_end) begin
            if (inside_unit && held_valid) begin
                emit_nal_word(held_byte, 1'b1);
            end
            inside_unit   = 1'b0;
            zero_run      = '0;
            held_valid    = 1'b0;
            first_pending = 1'b1;
            messages++;
        end
        burst = expected_words.size() - base;
        if (burst > 0) begin
            w = expected_words[expected_words.size() - 1];
            w.burst_end = 1'b1;
            expected_words[expected_words.size() - 1] = w;
            if (burst > longest_burst) begin
                longest_burst = burst;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [BYTE_W-1:0] b, input logic last);
        t_stream_word s;
        s.data    = b;
        s.msg_end = last;
        pending_bytes.insert(pending_bytes.size(), s);
    endtask

    // Lean toward zeros and 01 so start codes and zero runs show up often.
    function automatic logic [BYTE_W-1:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) begin
            return 8'h00;
        end else if (r == 2) begin
            return 8'h01;
        end else if (r == 3) begin
            return 8'hFF;
        end
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic add_zeros(input int n);
        for (int i = 0; i < n; i++) begin
            add_byte(8'h00, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int directed;
        int n;
        int nunits;

        // junk before the first start code, then a 3-byte code
        add_byte(8'hAA, 1'b0);
        add_zeros(2);
        add_byte(8'h01, 1'b0);
        // payload at the byte extremes
        add_byte(8'hFF, 1'b0);
        add_byte(8'h80, 1'b0);
        // 4-byte code closes the unit, its extra zero is stripped
        add_zeros(3);
        add_byte(8'h01, 1'b0);
        // start code right away: empty unit, nothing out
        add_zeros(2);
        add_byte(8'h01, 1'b0);
        // inner zero kept, 01 after a single zero is payload, plain 01 too
        add_byte(8'h7F, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(8'h01, 1'b0);
        // trailing zeros dropped at message end
        add_byte(8'h00, 1'b0);
        add_byte(8'h00, 1'b1);
        // message ending on a start code, then one outside any unit
        add_zeros(2);
        add_byte(8'h01, 1'b1);
        add_byte(8'h5A, 1'b1);
        directed = pending_bytes.size();

        while (pending_bytes.size() < directed + RANDOM_BYTES) begin
            if ($urandom_range(0, 6) == 0) begin
                // raw noise message
                n = $urandom_range(1, 10);
                for (int i = 0; i < n; i++) begin
                    add_byte(pick_byte(), i == n - 1);
                end
            end else begin
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++) begin
                    add_byte(BYTE_W'($urandom_range(2, 255)), 1'b0);
                end
                nunits = $urandom_range(1, 4);
                for (int u = 0; u < nunits; u++) begin
                    add_zeros($urandom_range(2, 4));
                    add_byte(8'h01, 1'b0);
                    n = $urandom_range(0, 12);
                    for (int k = 0; k < n; k++) begin
                        add_byte(pick_byte(), 1'b0);
                    end
                    // now and then a zero run around the cap
                    if ($urandom_range(0, 15) == 0) begin
                        add_zeros($urandom_range(56, 70));
                    end else if ($urandom_range(0, 1) == 0) begin
                        add_zeros($urandom_range(0, 3));
                    end
                end
                add_byte(pick_byte(), 1'b1);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || expected_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("annexb_nal_unit_splitter_test: %0d messages, %0d bytes in, %0d words out, %0d units",
                 messages, in_words, out_words, units);
        $display("annexb_nal_unit_splitter_test: longest burst %0d words, %0d zeros released at the cap",
                 longest_burst, cap_releases);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("annexb_nal_unit_splitter_test: clean");
        end else begin
            $display("annexb_nal_unit_splitter_test: errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                split_stream_byte(s_tdata, s_tlast);
                pending_bytes.delete(0);
                in_words++;
            end
            // hold the word while it waits; otherwise advance
            if (!s_tvalid || s_tready) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left != 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    s_tdata  <= pending_bytes[0].data;
                    s_tlast  <= pending_bytes[0].msg_end;
                    s_tvalid <= 1'b1;
                    burst_left--;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern changes at random intervals, plus one long
    // hold-off while the sender keeps offering bytes
    // ------------------------------------------------------------------------
    t_rx_mode   rx_mode = RX_FREE;
    int         mode_left = 0;
    int         hold_left = 0;
    logic       hold_done = 1'b0;
    logic [1:0] rx_phase = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && out_words >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            rx_phase = rx_phase + 1'b1;
            case (rx_mode)
                RX_FREE:     m_tready <= 1'b1;
                RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
                RX_PERIODIC: m_tready <= (rx_phase != 2'd3);
                default:     m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("annexb_nal_unit_splitter_test: mismatch at word %0d: %s got %0h want %0h",
                 out_words, what, got, want);
        err_count++;
    endtask

    t_nal_word want_word;

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("word with nothing pending, data", m_tdata, 0);
            end else begin
                want_word = expected_words.pop_front();
                if (m_tdata != want_word.data) begin
                    report_mismatch("nal_byte", m_tdata, want_word.data);
                end
                if (m_tuser[0] != want_word.first) begin
                    report_mismatch("nal_first", m_tuser[0], want_word.first);
                end
                if (m_tlast != want_word.last) begin
                    report_mismatch("nal_last", m_tlast, want_word.last);
                end
                if (m_tuser[1] != want_word.burst_end) begin
                    report_mismatch("burst_last", m_tuser[1], want_word.burst_end);
                end
                if (want_word.first) begin
                    units++;
                end
            end
            out_words++;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if neither side moves a word for too long
    // ------------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("annexb_nal_unit_splitter_test: stuck for %0d cycles, %0d words pending",
                     idle_cycles, expected_words.size());
            $display("annexb_nal_unit_splitter_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
